>>> src/fcba_pkg.sv
package fcba_pkg;

  localparam int NUM_BLOCKS  = 2048;
  localparam int BLOCK_BYTES = 4096;

  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int BYTES_W   = 24;
  localparam int MODE_W    = 3;
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int NEED_W    = BYTES_W - BLK_SHIFT + 1;

  localparam logic [MODE_W-1:0] MODE_FORMAT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  localparam logic [1:0] KIND_FREE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_LINK = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] nxt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BYTES_W-1:0] byte_size;
    logic [IDX_W-1:0]   chain_start;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] result_block;
    logic             is_end;
    logic             is_free;
    logic [CNT_W-1:0] block_count;
  } res_t;

endpackage

>>> src/fat_chain_block_allocator.sv
// channel   ports                    dir  beat taken when
// request   start, busy, in_req      in   start & !busy
// result    out_valid, out_res       out  out_valid, one cycle only
//
// read entry: S_READ_RD, then S_READ_DAT; format: one table row written per cycle
// allocate: one table read per cycle on the ram port while scanning for free blocks
// append: allocate after walking the chain to its end entry, then link the new run on
// free: walk the chain, freeing each entry visited, then the result beat
// after reset busy is high while the table is cleared (blocks 0, 1 end); no result
// the receiver cannot stall: each result beat is shown for one cycle
module fat_chain_block_allocator
  import fcba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output res_t out_res
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WALK_RD  = 4'd2;
  localparam logic [3:0] S_WALK_DAT = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_TERM     = 4'd6;
  localparam logic [3:0] S_LINK     = 4'd7;
  localparam logic [3:0] S_FREE_RD  = 4'd8;
  localparam logic [3:0] S_FREE_DAT = 4'd9;
  localparam logic [3:0] S_READ_RD  = 4'd10;
  localparam logic [3:0] S_READ_DAT = 4'd11;

  logic [3:0]        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              link_ok_r, link_ok_nxt;
  logic [CNT_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic              fmt_r, fmt_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  logic [NEED_W-1:0] req_need;

  fcba_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  function automatic res_t mk_res(logic st, logic [IDX_W-1:0] blk, logic e, logic f,
                                  logic [CNT_W-1:0] cnt);
    res_t r;
    r.status       = st;
    r.result_block = blk;
    r.is_end       = e;
    r.is_free      = f;
    r.block_count  = cnt;
    return r;
  endfunction

  assign req_need = NEED_W'(in_req.byte_size >> BLK_SHIFT)
                  + NEED_W'(|in_req.byte_size[BLK_SHIFT-1:0]);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    need_nxt      = need_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    taken_nxt     = taken_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    tail_nxt      = tail_r;
    link_ok_nxt   = link_ok_r;
    scan_addr_nxt = scan_addr_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    free_cnt_nxt  = free_cnt_r;
    clr_addr_nxt  = clr_addr_r;
    fmt_nxt       = fmt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '{kind: KIND_FREE, nxt: '0};
    ram_re        = 1'b0;
    ram_raddr     = cur_r;

    case (state_r)
      S_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = clr_addr_r;
        ram_wdata.kind = (clr_addr_r < IDX_W'(2)) ? KIND_END : KIND_FREE;
        clr_addr_nxt   = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(NUM_BLOCKS - 1)) begin
          free_cnt_nxt  = CNT_W'(NUM_BLOCKS - 2);
          state_nxt     = S_IDLE;
          out_valid_nxt = fmt_r;
          out_res_nxt   = mk_res(1'b0, '0, 1'b1, 1'b0, '0);
          fmt_nxt       = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt    = in_req.mode;
          need_nxt    = req_need;
          cur_nxt     = in_req.chain_start;
          steps_nxt   = '0;
          taken_nxt   = '0;
          link_ok_nxt = 1'b0;
          case (in_req.mode)
            MODE_FORMAT: begin
              clr_addr_nxt = '0;
              fmt_nxt      = 1'b1;
              state_nxt    = S_CLEAR;
            end
            MODE_ALLOC:  state_nxt = S_CHECK;
            MODE_APPEND: state_nxt = S_WALK_RD;
            MODE_FREE:   state_nxt = S_FREE_RD;
            MODE_READ:   state_nxt = S_READ_RD;
            default: begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = mk_res(1'b0, '0, 1'b1, 1'b0, '0);
            end
          endcase
        end
      end
      S_WALK_RD: begin
        if (steps_r == CNT_W'(NUM_BLOCKS)) begin
          state_nxt = S_CHECK;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_WALK_DAT;
        end
      end
      S_WALK_DAT: begin
        case (ram_rdata.kind)
          KIND_END: begin
            tail_nxt    = cur_r;
            link_ok_nxt = 1'b1;
            state_nxt   = S_CHECK;
          end
          KIND_LINK: begin
            cur_nxt   = ram_rdata.nxt;
            steps_nxt = steps_r + 1'b1;
            state_nxt = S_WALK_RD;
          end
          default: state_nxt = S_CHECK;
        endcase
      end
      S_CHECK: begin
        if (need_r == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = mk_res(1'b0, '0, 1'b1, 1'b0, '0);
          state_nxt     = S_IDLE;
        end else if (need_r > NEED_W'(free_cnt_r)) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = mk_res(1'b1, '0, 1'b1, 1'b0, '0);
          state_nxt     = S_IDLE;
        end else begin
          scan_addr_nxt = '0;
          taken_nxt     = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_raddr     = scan_addr_r[IDX_W-1:0];
        ram_re        = scan_addr_r < CNT_W'(NUM_BLOCKS);
        pend_nxt      = ram_re;
        pend_addr_nxt = scan_addr_r[IDX_W-1:0];
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (pend_r && ram_rdata.kind == KIND_FREE) begin
          if (taken_r == '0) begin
            first_nxt = pend_addr_r;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_r;
            ram_wdata = '{kind: KIND_LINK, nxt: pend_addr_r};
          end
          prev_nxt  = pend_addr_r;
          taken_nxt = taken_r + 1'b1;
          if (NEED_W'(taken_r) + 1'b1 == need_r) begin
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        ram_we       = 1'b1;
        ram_waddr    = prev_r;
        ram_wdata    = '{kind: KIND_END, nxt: '0};
        free_cnt_nxt = free_cnt_r - taken_r;
        out_res_nxt  = mk_res(1'b0, first_r, 1'b0, 1'b0, taken_r);
        if (mode_r == MODE_APPEND && link_ok_r) begin
          state_nxt = S_LINK;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LINK: begin
        ram_we        = 1'b1;
        ram_waddr     = tail_r;
        ram_wdata     = '{kind: KIND_LINK, nxt: first_r};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FREE_RD: begin
        if (steps_r == CNT_W'(NUM_BLOCKS)) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = mk_res(1'b0, '0, 1'b1, 1'b0, taken_r);
          state_nxt     = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_FREE_DAT;
        end
      end
      S_FREE_DAT: begin
        if (ram_rdata.kind == KIND_FREE) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = mk_res(1'b0, '0, 1'b1, 1'b0, taken_r);
          state_nxt     = S_IDLE;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = cur_r;
          ram_wdata    = '{kind: KIND_FREE, nxt: '0};
          taken_nxt    = taken_r + 1'b1;
          free_cnt_nxt = free_cnt_r + 1'b1;
          if (ram_rdata.kind == KIND_LINK) begin
            cur_nxt   = ram_rdata.nxt;
            steps_nxt = steps_r + 1'b1;
            state_nxt = S_FREE_RD;
          end else begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = mk_res(1'b0, '0, 1'b1, 1'b0, taken_r + 1'b1);
            state_nxt     = S_IDLE;
          end
        end
      end
      S_READ_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_READ_DAT;
      end
      S_READ_DAT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (ram_rdata.kind)
          KIND_FREE: out_res_nxt = mk_res(1'b0, '0, 1'b1, 1'b1, '0);
          KIND_LINK: out_res_nxt = mk_res(1'b0, ram_rdata.nxt, 1'b0, 1'b0, '0);
          default:   out_res_nxt = mk_res(1'b0, '0, 1'b1, 1'b0, '0);
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      fmt_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      free_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fmt_r       <= fmt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      free_cnt_r  <= free_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    need_r      <= need_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    taken_r     <= taken_nxt;
    first_r     <= first_nxt;
    prev_r      <= prev_nxt;
    tail_r      <= tail_nxt;
    link_ok_r   <= link_ok_nxt;
    scan_addr_r <= scan_addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> src/fcba_ram.sv
module fcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
